// ----- hdl/dispenser_frame_builder_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the dispenser frame builder
// Concurrent checks on the rising edge of aclk; DFB_ASSERT is masked while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef DISPENSER_FRAME_BUILDER_UNIT_ASSERT_SVH
`define DISPENSER_FRAME_BUILDER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define DFB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define DFB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

// ----- hdl/dfb_pkg.sv -----
// ----------------------------------------------------------------------------
// dfb_pkg
// Types, character codes and decimal tables shared by the frame builder.
// ----------------------------------------------------------------------------
package dfb_pkg;

    localparam int DFB_DECIMAL_DIGITS = 6;
    localparam int DFB_MAX_DIGITS     = 9;
    localparam int DFB_EXP_W          = $clog2(DFB_MAX_DIGITS);
    // wide enough for 9 * 10^8 and 10^9
    localparam int DFB_REM_W          = 30;

    localparam logic [7:0] DFB_CH_SOH  = 8'h01;
    localparam logic [7:0] DFB_CH_STX  = 8'h02;
    localparam logic [7:0] DFB_CH_ETX  = 8'h03;
    localparam logic [7:0] DFB_CH_ZERO = 8'd48;
    localparam logic [7:0] DFB_CH_HEX  = 8'd55;

    localparam logic [7:0] DFB_ADDR_MAX = 8'h7F;
    localparam logic [7:0] DFB_CMD_MAX  = 8'h0F;
    localparam logic [8:0] DFB_BYTE_MAX = 9'h0FF;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_ADDR   = 3'd1,
        ST_CMD    = 3'd2,
        ST_PRICE  = 3'd3,
        ST_VOLUME = 3'd4,
        ST_ERROR  = 3'd5,
        ST_CODE   = 3'd6
    } dfb_status_t;

    typedef struct packed {
        logic [8:0]  code_byte;
        logic [8:0]  error_byte;
        logic [19:0] volume;
        logic [19:0] price;
        logic [7:0]  command_code;
        logic [7:0]  pump_address;
    } dfb_req_t;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        last;
        dfb_status_t status;
    } dfb_byte_t;

    typedef struct packed {
        logic load;
        logic advance;
    } dfb_ctrl_t;

    // row e holds d * 10^e for d = 0..9
    typedef logic [9:0][DFB_REM_W-1:0] dfb_thr_row_t;
    typedef dfb_thr_row_t [DFB_MAX_DIGITS-1:0] dfb_thr_table_t;

    function automatic logic [DFB_REM_W-1:0] dfb_pow10(input int n);
        logic [DFB_REM_W-1:0] p;
        p = DFB_REM_W'(1);
        for (int i = 0; i < n; i++) begin
            p = p * DFB_REM_W'(10);
        end
        return p;
    endfunction

    function automatic dfb_thr_table_t dfb_thr_table();
        dfb_thr_table_t tbl;
        for (int e = 0; e < DFB_MAX_DIGITS; e++) begin
            for (int d = 0; d < 10; d++) begin
                tbl[e][d] = dfb_pow10(e) * DFB_REM_W'(d);
            end
        end
        return tbl;
    endfunction

    localparam dfb_thr_table_t DFB_THR = dfb_thr_table();

    function automatic logic [7:0] dfb_hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib > 4'd9) begin
            c = {4'd0, nib} + DFB_CH_HEX;
        end else begin
            c = {4'd0, nib} + DFB_CH_ZERO;
        end
        return c;
    endfunction

endpackage

// ----- hdl/dfb_frame_gen.sv -----
// ----------------------------------------------------------------------------
// dfb_frame_gen
// Holds the request in flight, checks it at load and produces one frame byte
// per advance, with one decimal digit extracted per cycle in which advance is high, and a running XOR.
// ----------------------------------------------------------------------------
`include "dispenser_frame_builder_unit_assert.svh"

module dfb_frame_gen
    import dfb_pkg::*;
#(
    parameter int DECIMAL_DIGITS = DFB_DECIMAL_DIGITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  dfb_ctrl_t ctrl,
    input  dfb_req_t  req,
    output logic      busy,
    output dfb_byte_t cur
);

    localparam int FRAME_LEN = 11 + 2 * DECIMAL_DIGITS;
    localparam int POS_W     = $clog2(FRAME_LEN);
    localparam int P_ADDR_HI = 1;
    localparam int P_ADDR_LO = 2;
    localparam int P_CMD     = 3;
    localparam int P_STX     = 4;
    localparam int P_PRICE   = 5;
    localparam int P_VOLUME  = P_PRICE + DECIMAL_DIGITS;
    localparam int P_ERR_HI  = P_VOLUME + DECIMAL_DIGITS;
    localparam int P_ERR_LO  = P_ERR_HI + 1;
    localparam int P_CODE_HI = P_ERR_HI + 2;
    localparam int P_CODE_LO = P_ERR_HI + 3;
    localparam int P_ETX     = P_ERR_HI + 4;
    localparam int P_CHK     = P_ERR_HI + 5;

    localparam logic [DFB_REM_W-1:0] LIMIT = dfb_pow10(DECIMAL_DIGITS) - DFB_REM_W'(1);
    localparam logic [DFB_EXP_W-1:0] EXP_TOP = DFB_EXP_W'(DECIMAL_DIGITS - 1);

    logic                  busy_reg, busy_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [DFB_EXP_W-1:0]  exp_reg, exp_next;
    logic [DFB_REM_W-1:0]  rem_reg, rem_next;
    logic [7:0]            chk_reg, chk_next;
    dfb_status_t           status_reg, status_next;
    dfb_req_t              req_reg;

    dfb_status_t           load_status;
    dfb_thr_row_t          thr_row;
    logic [3:0]            digit;
    logic                  is_digit;

    // range checks in field order, first failure wins
    always_comb begin
        if (req.pump_address > DFB_ADDR_MAX) begin
            load_status = ST_ADDR;
        end else if (req.command_code > DFB_CMD_MAX) begin
            load_status = ST_CMD;
        end else if ({{(DFB_REM_W-20){1'b0}}, req.price} > LIMIT) begin
            load_status = ST_PRICE;
        end else if ({{(DFB_REM_W-20){1'b0}}, req.volume} > LIMIT) begin
            load_status = ST_VOLUME;
        end else if (req.error_byte > DFB_BYTE_MAX) begin
            load_status = ST_ERROR;
        end else if (req.code_byte > DFB_BYTE_MAX) begin
            load_status = ST_CODE;
        end else begin
            load_status = ST_OK;
        end
    end

    // digit at the current power of ten: thresholds are monotone, last hit wins
    always_comb begin
        thr_row = DFB_THR[exp_reg];
        digit   = 4'd0;
        for (int d = 1; d < 10; d++) begin
            if (rem_reg >= thr_row[d]) begin
                digit = 4'(d);
            end
        end
    end

    always_comb begin
        cur.frame_byte = 8'h00;
        cur.last       = 1'b0;
        cur.status     = status_reg;
        is_digit       = 1'b0;
        if (status_reg != ST_OK) begin
            cur.last = 1'b1;
        end else begin
            case (pos_reg) inside
                P_ADDR_HI: cur.frame_byte = dfb_hex_char(req_reg.pump_address[7:4]);
                P_ADDR_LO: cur.frame_byte = dfb_hex_char(req_reg.pump_address[3:0]);
                P_CMD:     cur.frame_byte = dfb_hex_char(req_reg.command_code[3:0]);
                P_STX:     cur.frame_byte = DFB_CH_STX;
                [P_PRICE:P_ERR_HI-1]: begin
                    cur.frame_byte = DFB_CH_ZERO + {4'd0, digit};
                    is_digit       = 1'b1;
                end
                P_ERR_HI:  cur.frame_byte = dfb_hex_char(req_reg.error_byte[7:4]);
                P_ERR_LO:  cur.frame_byte = dfb_hex_char(req_reg.error_byte[3:0]);
                P_CODE_HI: cur.frame_byte = dfb_hex_char(req_reg.code_byte[7:4]);
                P_CODE_LO: cur.frame_byte = dfb_hex_char(req_reg.code_byte[3:0]);
                P_ETX:     cur.frame_byte = DFB_CH_ETX;
                P_CHK: begin
                    cur.frame_byte = chk_reg;
                    cur.last       = 1'b1;
                end
                default:   cur.frame_byte = DFB_CH_SOH;
            endcase
        end
    end

    assign busy = busy_reg;

    always_comb begin
        busy_next   = busy_reg;
        pos_next    = pos_reg;
        exp_next    = exp_reg;
        rem_next    = rem_reg;
        chk_next    = chk_reg;
        status_next = status_reg;
        if (ctrl.load) begin
            busy_next   = 1'b1;
            pos_next    = '0;
            exp_next    = EXP_TOP;
            rem_next    = {{(DFB_REM_W-20){1'b0}}, req.price};
            chk_next    = 8'h00;
            status_next = load_status;
        end else if (ctrl.advance) begin
            if (cur.last) begin
                busy_next = 1'b0;
            end else begin
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg != '0) begin
                    chk_next = chk_reg ^ cur.frame_byte;
                end
            end
            // move to the volume field once the price units digit leaves
            if (is_digit) begin
                if (exp_reg == '0) begin
                    exp_next = EXP_TOP;
                    rem_next = {{(DFB_REM_W-20){1'b0}}, req_reg.volume};
                end else begin
                    exp_next = exp_reg - DFB_EXP_W'(1);
                    rem_next = rem_reg - thr_row[digit];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        exp_reg    <= exp_next;
        rem_reg    <= rem_next;
        chk_reg    <= chk_next;
        status_reg <= status_next;
        if (ctrl.load) begin
            req_reg <= req;
        end
    end

    `DFB_ASSERT(a_load_when_free, ctrl.load |-> (!busy_reg || (ctrl.advance && cur.last)), "request loaded over a frame in flight")
    `DFB_ASSERT(a_load_starts, ctrl.load |=> (busy_reg && pos_reg == '0), "load did not start at the first byte")
    `DFB_ASSERT(a_error_single, (busy_reg && status_reg != ST_OK) |-> (cur.last && cur.frame_byte == 8'h00), "rejected request must give one zero byte")
    `DFB_ASSERT(a_exp_range, busy_reg |-> (exp_reg <= EXP_TOP), "digit exponent out of range")
    `DFB_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !busy_reg, "reset left the generator busy")

endmodule

// ----- hdl/dispenser_frame_builder_unit.sv -----
// ----------------------------------------------------------------------------
// dispenser_frame_builder_unit
// Range-checks a dispenser request and streams it out as an ASCII frame.
// ----------------------------------------------------------------------------
// A request word passing every check leaves as 11 + 2*DECIMAL_DIGITS frame
// bytes (23 by default), one byte per cycle on the result port while the sink
// keeps m_tready high; a rejected request gives a single zero byte with tlast
// set and the failing field's status in tuser. The one-byte result port sets
// the request rate. The next request is taken in the cycle the current frame's
// last byte moves into the output register; a byte stalled in that register
// holds up the input only while a frame is still in flight.

`include "dispenser_frame_builder_unit_assert.svh"

module dispenser_frame_builder_unit
    import dfb_pkg::*;
#(
    parameter int DECIMAL_DIGITS = DFB_DECIMAL_DIGITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // pump_address[7:0], command_code[15:8], price[35:16], volume[55:36],
    // error_byte[64:56], code_byte[73:65], zero fill [79:74]
    input  logic [79:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // frame_byte[7:0]
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    // status[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready
);

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg;
    logic       m_last_reg;
    logic [2:0] m_user_reg;

    dfb_ctrl_t  ctrl;
    dfb_req_t   req;
    dfb_byte_t  cur;
    logic       busy;
    logic       out_ready;

    assign req       = dfb_req_t'(s_tdata[73:0]);
    assign out_ready = !m_valid_reg || m_tready;

    assign ctrl.advance = busy && out_ready;
    assign s_tready     = !busy || (ctrl.advance && cur.last);
    assign ctrl.load    = s_tvalid && s_tready;

    dfb_frame_gen #(
        .DECIMAL_DIGITS(DECIMAL_DIGITS)
    ) u_frame_gen (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl   (ctrl),
        .req    (req),
        .busy   (busy),
        .cur    (cur)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // hold the word until the sink takes it
    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            m_data_reg <= cur.frame_byte;
            m_last_reg <= cur.last;
            m_user_reg <= cur.status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    `DFB_ASSERT(a_no_overwrite, (m_valid_reg && !m_tready) |-> !ctrl.advance, "output word overwritten while stalled")
    `DFB_ASSERT(a_err_is_last, (m_valid_reg && m_user_reg != ST_OK) |-> (m_last_reg && m_data_reg == 8'h00), "error word must be a lone zero byte")
    `DFB_ASSERT(a_accept_idle_gen, (s_tvalid && s_tready) |=> busy, "accepted request did not start")

endmodule

// ----- tb/dispenser_frame_builder_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dispenser_frame_builder_unit_test
// Sends dispenser requests, in range and out of range, and compares every
// result word with the frame or error status worked out for the request.
// ----------------------------------------------------------------------------
module dispenser_frame_builder_unit_test;
    import dfb_pkg::*;

    localparam int REQ_W      = $bits(dfb_req_t);
    localparam int DIGITS     = DFB_DECIMAL_DIGITS;
    localparam int AMOUNT_MAX = 10 ** DIGITS - 1;
    localparam int LONG_HOLD  = 400;

    class frame_scoreboard;
        dfb_byte_t frames_due[$];
        int        mismatches;

        function logic [7:0] hex_ascii(logic [3:0] nib);
            return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h41 + 8'(nib) - 8'd10;
        endfunction

        // fields are checked in input order, the first failure wins
        function dfb_status_t first_bad_field(dfb_req_t r);
            if (r.pump_address > DFB_ADDR_MAX) return ST_ADDR;
            if (r.command_code > DFB_CMD_MAX) return ST_CMD;
            if (int'(r.price) > AMOUNT_MAX) return ST_PRICE;
            if (int'(r.volume) > AMOUNT_MAX) return ST_VOLUME;
            if (r.error_byte > DFB_BYTE_MAX) return ST_ERROR;
            if (r.code_byte > DFB_BYTE_MAX) return ST_CODE;
            return ST_OK;
        endfunction

        function void note_request(dfb_req_t r);
            dfb_status_t verdict;
            logic [7:0]  text[$];
            logic [7:0]  sum;
            int          value;
            dfb_byte_t   b;
            verdict = first_bad_field(r);
            if (verdict != ST_OK) begin
                b.frame_byte = 8'h00;
                b.last       = 1'b1;
                b.status     = verdict;
                frames_due.push_back(b);
                return;
            end
            text.push_back(DFB_CH_SOH);
            text.push_back(hex_ascii(r.pump_address[7:4]));
            text.push_back(hex_ascii(r.pump_address[3:0]));
            text.push_back(hex_ascii(r.command_code[3:0]));
            text.push_back(DFB_CH_STX);
            for (int f = 0; f < 2; f++) begin
                value = (f == 0) ? int'(r.price) : int'(r.volume);
                for (int k = DIGITS - 1; k >= 0; k--) begin
                    text.push_back(8'h30 + 8'((value / (10 ** k)) % 10));
                end
            end
            text.push_back(hex_ascii(r.error_byte[7:4]));
            text.push_back(hex_ascii(r.error_byte[3:0]));
            text.push_back(hex_ascii(r.code_byte[7:4]));
            text.push_back(hex_ascii(r.code_byte[3:0]));
            text.push_back(DFB_CH_ETX);
            // check byte skips SOH
            sum = 8'h00;
            for (int i = 1; i < text.size(); i++) begin
                sum ^= text[i];
            end
            text.push_back(sum);
            foreach (text[i]) begin
                b.frame_byte = text[i];
                b.last       = (i == text.size() - 1);
                b.status     = ST_OK;
                frames_due.push_back(b);
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_word(logic [7:0] data, logic tlast, logic [2:0] tuser);
            dfb_byte_t want;
            if (frames_due.size() == 0) begin
                report("word with nothing pending", 32'(data), 32'h0);
                return;
            end
            want = frames_due.pop_front();
            if (data !== want.frame_byte) begin
                report("frame byte", 32'(data), 32'(want.frame_byte));
            end
            if (tlast !== want.last) report("tlast", 32'(tlast), 32'(want.last));
            if (tuser !== want.status) report("status", 32'(tuser), 32'(want.status));
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic [79:0] s_tdata  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    frame_scoreboard sb = new();
    bit              idle_on           = 1'b1;
    bit              sink_hold_pending = 1'b0;

    dispenser_frame_builder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("** dispenser_frame_builder_unit: FAILED **");
        $finish;
    end

    // sink: random stall bursts, calm stretches, and one long hold on request
    initial begin : sink_drive
        int stall;
        int calm;
        stall = 0;
        calm  = 0;
        forever begin
            @(posedge aclk);
            if (sink_hold_pending) begin
                sink_hold_pending = 1'b0;
                stall = LONG_HOLD;
            end else if (stall == 0 && idle_on) begin
                if (calm > 0) begin
                    calm--;
                end else if ($urandom_range(0, 39) == 0) begin
                    calm = $urandom_range(30, 100);
                end else if ($urandom_range(0, 7) == 0) begin
                    stall = $urandom_range(1, 13);
                end
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_word(m_tdata, m_tlast, m_tuser);
        end
    end

    task automatic send_request(input dfb_req_t r);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, r};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
    endtask

    task automatic send_fields(input logic [7:0] addr, input logic [7:0] cmd,
                               input logic [19:0] price, input logic [19:0] volume,
                               input logic [8:0] err, input logic [8:0] code);
        dfb_req_t r;
        r.pump_address = addr;
        r.command_code = cmd;
        r.price        = price;
        r.volume       = volume;
        r.error_byte   = err;
        r.code_byte    = code;
        send_request(r);
    endtask

    // mostly well-formed requests, some with one field out of range, some noise
    function automatic dfb_req_t random_request();
        dfb_req_t r;
        int       pick;
        r.pump_address = 8'($urandom_range(0, 127));
        r.command_code = 8'($urandom_range(0, 15));
        r.price        = 20'($urandom_range(0, AMOUNT_MAX));
        r.volume       = 20'($urandom_range(0, AMOUNT_MAX));
        r.error_byte   = 9'($urandom_range(0, 255));
        r.code_byte    = 9'($urandom_range(0, 255));
        pick = $urandom_range(0, 19);
        if (pick >= 17) begin
            r = REQ_W'({$urandom(), $urandom(), $urandom()});
        end else if (pick >= 12) begin
            case ($urandom_range(0, 5))
                0: r.pump_address = 8'($urandom_range(128, 255));
                1: r.command_code = 8'($urandom_range(16, 255));
                2: r.price        = 20'($urandom_range(AMOUNT_MAX + 1, 20'hFFFFF));
                3: r.volume       = 20'($urandom_range(AMOUNT_MAX + 1, 20'hFFFFF));
                4: r.error_byte   = 9'($urandom_range(256, 511));
                default: r.code_byte = 9'($urandom_range(256, 511));
            endcase
        end
        return r;
    endfunction

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // in-range extremes and hex letters
        send_fields(8'h00, 8'h00, 20'd0, 20'd0, 9'h000, 9'h000);
        send_fields(8'h7F, 8'h0F, 20'd999999, 20'd999999, 9'h0FF, 9'h0FF);
        send_fields(8'h5A, 8'h0A, 20'd123456, 20'd654321, 9'h0BC, 9'h0DE);
        send_fields(8'h3C, 8'h09, 20'd100000, 20'd9, 9'h0A0, 9'h00F);
        // one field past its limit
        send_fields(8'h80, 8'h01, 20'd1, 20'd1, 9'h001, 9'h001);
        send_fields(8'hFF, 8'h01, 20'd1, 20'd1, 9'h001, 9'h001);
        send_fields(8'h01, 8'h10, 20'd1, 20'd1, 9'h001, 9'h001);
        send_fields(8'h01, 8'hFF, 20'd1, 20'd1, 9'h001, 9'h001);
        send_fields(8'h01, 8'h01, 20'd1000000, 20'd1, 9'h001, 9'h001);
        send_fields(8'h01, 8'h01, 20'hFFFFF, 20'd1, 9'h001, 9'h001);
        send_fields(8'h01, 8'h01, 20'd1, 20'd1000000, 9'h001, 9'h001);
        send_fields(8'h01, 8'h01, 20'd1, 20'hFFFFF, 9'h001, 9'h001);
        send_fields(8'h01, 8'h01, 20'd1, 20'd1, 9'h100, 9'h001);
        send_fields(8'h01, 8'h01, 20'd1, 20'd1, 9'h1FF, 9'h001);
        send_fields(8'h01, 8'h01, 20'd1, 20'd1, 9'h001, 9'h100);
        send_fields(8'h01, 8'h01, 20'd1, 20'd1, 9'h001, 9'h1FF);
        // several failures: the earliest field decides; the last request is in range
        send_fields(8'hFF, 8'hFF, 20'hFFFFF, 20'hFFFFF, 9'h1FF, 9'h1FF);
        send_fields(8'h10, 8'h20, 20'hFFFFF, 20'd5, 9'h000, 9'h000);
        send_fields(8'h10, 8'h02, 20'd1000000, 20'hFFFFF, 9'h1FF, 9'h000);
        send_fields(8'h10, 8'h02, 20'd5, 20'd5, 9'h1AB, 9'h1CD);
        send_fields(8'h7F, 8'h0F, 20'd999999, 20'd0, 9'h0FF, 9'h000);

        for (int n = 0; n < 109; n++) begin
            // fill the block while the sink holds off
            if (n == 40) sink_hold_pending = 1'b1;
            if (n == 90) idle_on = 1'b0;
            send_request(random_request());
        end
        s_tvalid <= 1'b0;

        while (sb.frames_due.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("** dispenser_frame_builder_unit: PASSED **");
        end else begin
            $display("** dispenser_frame_builder_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ----- dispenser_frame_builder_unit.f -----
+incdir+hdl
hdl/dfb_pkg.sv
hdl/dfb_frame_gen.sv
hdl/dispenser_frame_builder_unit.sv
tb/dispenser_frame_builder_unit_test.sv
